// ===== hw/rtl/point_to_line_distance_assert.svh =====
// Assertion macros shared by the RTL. Each expects clk and rst_n in scope.
`ifndef POINT_TO_LINE_DISTANCE_ASSERT_SVH
`define POINT_TO_LINE_DISTANCE_ASSERT_SVH

// Same-cycle implication.
`define PTL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PTL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ptl_pkg.sv =====
package ptl_pkg;

    localparam int COORD_W = 32;
    localparam int DIST_W  = 31;
    localparam int DIFF_W  = 33;
    localparam int PROD_W  = 66;
    localparam int CMAG_W  = 67;
    localparam int LEN_W   = 67;
    localparam int LO_W    = 33;
    localparam int HI_W    = CMAG_W - LO_W;
    localparam int REM_W   = 136;

    typedef logic [REM_W-1:0]  rem_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [DIST_W-1:0] dist_t;

    // Per query point state carried down the cell row.
    typedef struct packed {
        rem_t  rem;   // C^2 - d^2 * L
        rem_t  dl;    // d * L
        dist_t d;
    } lane_t;

    // Per request control shared by all lanes of a stage.
    typedef struct packed {
        logic vld;
        logic degen;
        len_t len;
    } ctl_t;

endpackage

// ===== hw/rtl/ptl_if.sv =====
interface ptl_req_if #(parameter int NUM_POINTS = 3);
    logic                                         valid;
    logic                                         ready;
    logic [NUM_POINTS-1:0][ptl_pkg::COORD_W-1:0] point_lat;
    logic [NUM_POINTS-1:0][ptl_pkg::COORD_W-1:0] point_lon;
    logic signed [ptl_pkg::COORD_W-1:0]          line_start_lat;
    logic signed [ptl_pkg::COORD_W-1:0]          line_start_lon;
    logic signed [ptl_pkg::COORD_W-1:0]          line_end_lat;
    logic signed [ptl_pkg::COORD_W-1:0]          line_end_lon;

    modport source (
        output valid, point_lat, point_lon, line_start_lat, line_start_lon,
               line_end_lat, line_end_lon,
        input  ready
    );
    modport sink (
        input  valid, point_lat, point_lon, line_start_lat, line_start_lon,
               line_end_lat, line_end_lon,
        output ready
    );
endinterface

interface ptl_rsp_if #(parameter int NUM_POINTS = 3);
    logic                                        valid;
    logic                                        ready;
    logic [NUM_POINTS-1:0][ptl_pkg::DIST_W-1:0] distance;
    logic                                        degenerate;

    modport source (output valid, distance, degenerate, input ready);
    modport sink (input valid, distance, degenerate, output ready);
endinterface

// ===== hw/rtl/point_to_line_distance.sv =====
// Perpendicular distance of NUM_POINTS query points to the line through two
// points, all coordinates signed Q9.22 degrees.
// Channels: req (ptl_req_if.sink) carries the query points and both line
// points; rsp (ptl_rsp_if.source) returns one distance per point, unsigned
// Q9.22 truncated, saturating at 2^31-1 LSB, plus the degenerate flag.
// Handshake: a request or response moves on a clock edge with valid and ready.
// Throughput: one request per cycle, sustained while responses are taken on rsp.
// Pipeline: 5 front stages (differences,
// 33x33 products, L and |C|, partial products of C^2, sum), one cell per
// distance bit (31 cells, each deciding one bit of every distance), and
// the output register.
// Stall: the whole pipeline holds while a response waits on rsp.ready;
// req.ready is high whenever the output register is empty or being drained.
// Reset: rst_n clears all valid bits; no request is in flight afterwards.
// Coincident line points give degenerate = 1 and all distances zero.
`include "point_to_line_distance_assert.svh"

module point_to_line_distance #(
    parameter int NUM_POINTS = 3
) (
    input logic        clk,
    input logic        rst_n,
    ptl_req_if.sink    req,
    ptl_rsp_if.source  rsp
);
    import ptl_pkg::*;

    localparam int NCELL = DIST_W;

    logic                                 adv;
    ctl_t                                 ctl  [NCELL+1];
    lane_t [NUM_POINTS-1:0]               lane [NCELL+1];
    logic                                 vld_reg;
    logic                                 degen_reg;
    logic [NUM_POINTS-1:0][DIST_W-1:0]    dist_reg;

    assign adv       = !vld_reg || rsp.ready;
    assign req.ready = adv;

    ptl_front #(.NUM_POINTS(NUM_POINTS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_vld    (req.valid),
        .point_lat (req.point_lat),
        .point_lon (req.point_lon),
        .start_lat (req.line_start_lat),
        .start_lon (req.line_start_lon),
        .end_lat   (req.line_end_lat),
        .end_lon   (req.line_end_lon),
        .ctl       (ctl[0]),
        .lane      (lane[0])
    );

    // Most significant distance bit first.
    for (genvar c = 0; c < NCELL; c++)
    begin : g_cell
        ptl_cell #(.NUM_POINTS(NUM_POINTS), .BIT(NCELL-1-c)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .ctl_in   (ctl[c]),
            .lane_in  (lane[c]),
            .ctl_out  (ctl[c+1]),
            .lane_out (lane[c+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= ctl[NCELL].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            degen_reg <= ctl[NCELL].degen;
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                dist_reg[i] <= ctl[NCELL].degen ? '0 : lane[NCELL][i].d;
            end
        end
    end

    assign rsp.valid      = vld_reg;
    assign rsp.distance   = dist_reg;
    assign rsp.degenerate = degen_reg;

    `PTL_ASSERT_IMP(a_degen_zero, rsp.valid && rsp.degenerate, rsp.distance == '0, "degenerate with nonzero distance")
    `PTL_ASSERT_NXT(a_last_cell_out, ctl[NCELL].vld && adv, rsp.valid, "result lost at output register")
    `PTL_ASSERT_IMP(a_empty_ready, !rsp.valid, req.ready, "empty pipeline not accepting requests")

endmodule

// ===== hw/rtl/ptl_front.sv =====
module ptl_front #(
    parameter int NUM_POINTS = 3
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          adv,
    input  logic                                          in_vld,
    input  logic [NUM_POINTS-1:0][ptl_pkg::COORD_W-1:0]  point_lat,
    input  logic [NUM_POINTS-1:0][ptl_pkg::COORD_W-1:0]  point_lon,
    input  logic signed [ptl_pkg::COORD_W-1:0]           start_lat,
    input  logic signed [ptl_pkg::COORD_W-1:0]           start_lon,
    input  logic signed [ptl_pkg::COORD_W-1:0]           end_lat,
    input  logic signed [ptl_pkg::COORD_W-1:0]           end_lon,
    output ptl_pkg::ctl_t                                 ctl,
    output ptl_pkg::lane_t [NUM_POINTS-1:0]               lane
);
    import ptl_pkg::*;

    // stage 1: differences
    logic [4:0]                vld_reg;
    logic signed [DIFF_W-1:0]  dlat_reg, dlon_reg;
    logic signed [DIFF_W-1:0]  pa_reg [NUM_POINTS];
    logic signed [DIFF_W-1:0]  pb_reg [NUM_POINTS];
    // stage 2: products
    logic signed [PROD_W-1:0]  sq_lat_reg, sq_lon_reg;
    logic signed [PROD_W-1:0]  t1_reg [NUM_POINTS];
    logic signed [PROD_W-1:0]  t2_reg [NUM_POINTS];
    // stage 3: L and |C|
    len_t                      len3_reg;
    logic                      degen3_reg;
    logic [CMAG_W-1:0]         cmag_reg [NUM_POINTS];
    // stage 4: partial products of C^2
    len_t                      len4_reg;
    logic                      degen4_reg;
    logic [2*HI_W-1:0]         phh_reg [NUM_POINTS];
    logic [CMAG_W-1:0]         phl_reg [NUM_POINTS];
    logic [2*LO_W-1:0]         pll_reg [NUM_POINTS];
    // stage 5: into the cell row
    ctl_t                      ctl_reg;
    lane_t [NUM_POINTS-1:0]    lane_reg;

    logic signed [CMAG_W-1:0]  cdiff_next [NUM_POINTS];
    len_t                      len_next;

    always_comb
    begin
        len_next = len_t'($unsigned(sq_lat_reg)) + len_t'($unsigned(sq_lon_reg));
        for (int i = 0; i < NUM_POINTS; i++)
        begin
            cdiff_next[i] = CMAG_W'(t1_reg[i]) - CMAG_W'(t2_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dlat_reg   <= DIFF_W'(end_lat) - DIFF_W'(start_lat);
            dlon_reg   <= DIFF_W'(end_lon) - DIFF_W'(start_lon);
            sq_lat_reg <= dlat_reg * dlat_reg;
            sq_lon_reg <= dlon_reg * dlon_reg;
            len3_reg   <= len_next;
            // L is zero exactly when both line deltas are zero
            degen3_reg <= (len_next == '0) ? 1'b1 : 1'b0;
            len4_reg   <= len3_reg;
            degen4_reg <= degen3_reg;
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                pa_reg[i]   <= DIFF_W'($signed(point_lat[i])) - DIFF_W'(start_lat);
                pb_reg[i]   <= DIFF_W'($signed(point_lon[i])) - DIFF_W'(start_lon);
                t1_reg[i]   <= dlon_reg * pa_reg[i];
                t2_reg[i]   <= dlat_reg * pb_reg[i];
                cmag_reg[i] <= cdiff_next[i][CMAG_W-1] ? CMAG_W'(-cdiff_next[i])
                                                        : CMAG_W'(cdiff_next[i]);
                phh_reg[i]  <= cmag_reg[i][CMAG_W-1:LO_W] * cmag_reg[i][CMAG_W-1:LO_W];
                phl_reg[i]  <= cmag_reg[i][CMAG_W-1:LO_W] * cmag_reg[i][LO_W-1:0];
                pll_reg[i]  <= cmag_reg[i][LO_W-1:0] * cmag_reg[i][LO_W-1:0];
                lane_reg[i].rem <= (rem_t'(phh_reg[i]) << (2*LO_W))
                                 + (rem_t'(phl_reg[i]) << (LO_W+1))
                                 + rem_t'(pll_reg[i]);
                lane_reg[i].dl  <= '0;
                lane_reg[i].d   <= '0;
            end
            ctl_reg.vld   <= vld_reg[3];
            ctl_reg.len   <= len4_reg;
            ctl_reg.degen <= degen4_reg;
        end
    end

    always_comb
    begin
        ctl     = ctl_reg;
        ctl.vld = vld_reg[4];
    end

    assign lane = lane_reg;

endmodule

// ===== hw/rtl/ptl_cell.sv =====
module ptl_cell #(
    parameter int NUM_POINTS = 3,
    parameter int BIT        = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  ptl_pkg::ctl_t                    ctl_in,
    input  ptl_pkg::lane_t [NUM_POINTS-1:0]  lane_in,
    output ptl_pkg::ctl_t                    ctl_out,
    output ptl_pkg::lane_t [NUM_POINTS-1:0]  lane_out
);
    import ptl_pkg::*;

    logic                    vld_reg;
    ctl_t                    ctl_reg;
    lane_t [NUM_POINTS-1:0]  lane_reg;
    lane_t [NUM_POINTS-1:0]  lane_next;
    rem_t                    delta [NUM_POINTS];

    // Setting bit b of d grows d^2*L by (2*d*L + 2^b*L) * 2^b.
    always_comb
    begin
        for (int i = 0; i < NUM_POINTS; i++)
        begin
            delta[i]     = (lane_in[i].dl << (BIT+1)) + (rem_t'(ctl_in.len) << (2*BIT));
            lane_next[i] = lane_in[i];
            if (delta[i] <= lane_in[i].rem)
            begin
                lane_next[i].rem    = lane_in[i].rem - delta[i];
                lane_next[i].dl     = lane_in[i].dl + (rem_t'(ctl_in.len) << BIT);
                lane_next[i].d[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= ctl_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg  <= ctl_in;
            lane_reg <= lane_next;
        end
    end

    always_comb
    begin
        ctl_out     = ctl_reg;
        ctl_out.vld = vld_reg;
    end

    assign lane_out = lane_reg;

endmodule

// ===== tb/tb_point_to_line_distance.sv =====
module tb_point_to_line_distance;
    import ptl_pkg::*;

    localparam int NPTS = 3;
    localparam int N_RANDOM = 500;
    localparam int STALL_LIMIT = 2000;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct {
        coord_t plat [NPTS];
        coord_t plon [NPTS];
        coord_t alat, alon, blat, blon;
    } geom_t;

    typedef struct {
        dist_t d [NPTS];
        logic  degen;
    } dists_t;

    // Largest d < 2^31 with d*d*L <= C*C, by bit-serial search.
    function automatic dist_t isqrt_quot(logic [135:0] csq, logic [135:0] len);
        logic [135:0] t;
        logic [135:0] prod;
        dist_t d;
        d = '0;
        for (int b = DIST_W - 1; b >= 0; b--) begin
            t = {105'd0, d} | (136'd1 << b);
            prod = t * t * len;
            if (prod <= csq)
                d = t[DIST_W-1:0];
        end
        return d;
    endfunction

    function automatic dists_t line_dist(geom_t g);
        dists_t r;
        logic signed [67:0] dlat, dlon, pa, pb, c;
        logic [135:0] len, cm;
        dlat = 68'(g.blat) - 68'(g.alat);
        dlon = 68'(g.blon) - 68'(g.alon);
        len = 136'(dlat * dlat) + 136'(dlon * dlon);
        r.degen = (dlat == 0) && (dlon == 0);
        for (int i = 0; i < NPTS; i++) begin
            pa = 68'(g.plat[i]) - 68'(g.alat);
            pb = 68'(g.plon[i]) - 68'(g.alon);
            c = dlon * pa - dlat * pb;
            cm = 136'(c < 0 ? -c : c);
            r.d[i] = r.degen ? '0 : isqrt_quot(cm * cm, len);
        end
        return r;
    endfunction

    class dist_scoreboard;
        dists_t pending[$];
        int errors;

        function void note_request(geom_t g);
            pending.push_back(line_dist(g));
        endfunction

        function void check_response(dist_t d [NPTS], logic degen);
            dists_t e;
            if (pending.size() == 0) begin
                $error("response with no request outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int i = 0; i < NPTS; i++)
                if (d[i] !== e.d[i]) begin
                    $error("dist%0d: expected %0d, got %0d", i, e.d[i], d[i]);
                    errors++;
                end
            if (degen !== e.degen) begin
                $error("degenerate: expected %0b, got %0b", e.degen, degen);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    ptl_req_if #(.NUM_POINTS(NPTS)) req_ch ();
    ptl_rsp_if #(.NUM_POINTS(NPTS)) rsp_ch ();

    point_to_line_distance #(.NUM_POINTS(NPTS)) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch.sink),
        .rsp  (rsp_ch.source)
    );

    dist_scoreboard sb;
    geom_t stim[$];
    logic driving_done;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic coord_t rnd_coord(int mode);
        case (mode)
            0: return coord_t'($urandom());
            1: return coord_t'($urandom_range(0, 8) == 0 ? 32'h8000_0000 : 32'h7fff_ffff);
            default: return coord_t'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic geom_t rnd_geom();
        geom_t g;
        int mode;
        mode = $urandom_range(0, 3);
        g.alat = rnd_coord(mode == 3 ? 2 : mode);
        g.alon = rnd_coord(mode == 3 ? 2 : mode);
        g.blat = rnd_coord(mode == 3 ? 2 : mode);
        g.blon = rnd_coord(mode == 3 ? 2 : mode);
        if ($urandom_range(0, 15) == 0)
        begin
            g.blat = g.alat;
            g.blon = g.alon;
        end
        else if ($urandom_range(0, 7) == 0)
            g.blat = g.alat + coord_t'($urandom_range(0, 3));
        for (int i = 0; i < NPTS; i++) begin
            g.plat[i] = (mode == 3) ? g.alat + rnd_coord(2) : rnd_coord($urandom_range(0, 2));
            g.plon[i] = (mode == 3) ? g.alon + rnd_coord(2) : rnd_coord($urandom_range(0, 2));
        end
        return g;
    endfunction

    function automatic geom_t flat_geom(coord_t p, coord_t a, coord_t b);
        geom_t g;
        for (int i = 0; i < NPTS; i++) begin
            g.plat[i] = p;
            g.plon[i] = ~p;
        end
        g.alat = a;
        g.alon = a;
        g.blat = b;
        g.blon = ~b;
        return g;
    endfunction

    task automatic build_stimulus();
        geom_t g;
        // extremes, coincident line points, saturation, tiny lines
        stim.push_back(flat_geom(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
        stim.push_back(flat_geom(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
        stim.push_back(flat_geom(32'h0, 32'h0, 32'h0));
        stim.push_back(flat_geom(32'hffff_ffff, 32'h0, 32'h1));
        stim.push_back(flat_geom(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        g = flat_geom(32'h8000_0000, 32'h0, 32'h0);
        g.alat = 32'h8000_0000; g.alon = 32'h8000_0000;
        g.blat = 32'h8000_0001; g.blon = 32'h8000_0000;
        g.plon[0] = 32'h7fff_ffff; g.plon[1] = 32'h8000_0000; g.plon[2] = 32'h0;
        stim.push_back(g);
        g.blat = g.alat; g.blon = g.alon;
        stim.push_back(g);
        g = flat_geom(32'h1234_5678, 32'h7fff_ffff, 32'h7fff_ffff);
        g.blon = 32'h7fff_ffff;
        stim.push_back(g);
        for (int i = 0; i < 10; i++)
            stim.push_back(rnd_geom());
        for (int i = 0; i < N_RANDOM; i++)
            stim.push_back(rnd_geom());
    endtask

    task automatic send_requests();
        geom_t g;
        int gap;
        while (stim.size() > 0) begin
            g = stim.pop_front();
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
            // drop valid while idling so the last request is not taken twice
            if (gap != 0)
                req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            req_ch.valid <= 1'b1;
            for (int i = 0; i < NPTS; i++) begin
                req_ch.point_lat[i] <= g.plat[i];
                req_ch.point_lon[i] <= g.plon[i];
            end
            req_ch.line_start_lat <= g.alat;
            req_ch.line_start_lon <= g.alon;
            req_ch.line_end_lat <= g.blat;
            req_ch.line_end_lon <= g.blon;
            do @(posedge clk); while (!req_ch.ready);
            sb.note_request(g);
        end
        req_ch.valid <= 1'b0;
        driving_done = 1'b1;
    endtask

    task automatic take_responses();
        dist_t d [NPTS];
        int gap;
        forever begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
            if (gap != 0)
                rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clk);
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            for (int i = 0; i < NPTS; i++)
                d[i] = rsp_ch.distance[i];
            sb.check_response(d, rsp_ch.degenerate);
        end
    endtask

    // watchdog: cycles without any handshake
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("tb_point_to_line_distance: done, errors");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        driving_done = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.point_lat = '0;
        req_ch.point_lon = '0;
        req_ch.line_start_lat = '0;
        req_ch.line_start_lon = '0;
        req_ch.line_end_lat = '0;
        req_ch.line_end_lon = '0;
        rsp_ch.ready = 1'b0;
        build_stimulus();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            send_requests();
            take_responses();
        join_none
        wait (driving_done);
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_point_to_line_distance: done, clean");
        else
            $display("tb_point_to_line_distance: done, errors");
        $finish;
    end
endmodule
